>>> hdl/gossip_heartbeat_membership_table_defines.svh
// Assertion macros for the membership table.
`ifndef GOSSIP_HEARTBEAT_MEMBERSHIP_TABLE_DEFINES_SVH
`define GOSSIP_HEARTBEAT_MEMBERSHIP_TABLE_DEFINES_SVH

`ifndef SYNTH
`define GHMT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ghmt assertion failed");
`define GHMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ghmt assertion failed");
`else
`define GHMT_ASSERT_IMPL(lbl, ante, cons)
`define GHMT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/ghmt_pkg.sv
package ghmt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int EMIT_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_PORT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_TO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_TO  = 2'd3;

  // room for the self entry is kept back
  localparam logic [EMIT_W-1:0] EMIT_CAP = 5'd31;

  localparam logic [15:0] FAIL_TO_RST   = 16'd5;
  localparam logic [15:0] REMOVE_TO_RST = 16'd20;
  localparam logic [30:0] BEAT_MAX      = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    EV_UPDATED = 3'd0,
    EV_STALE   = 3'd1,
    EV_ADDED   = 3'd2,
    EV_DROPPED = 3'd3,
    EV_REMOVED = 3'd4,
    EV_GOSSIP  = 3'd5
  } event_kind_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [30:0] beat;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] id;
    logic [15:0] port;
    logic [30:0] beat;
    logic        last;
  } result_t;

endpackage

>>> hdl/ghmt_if.sv
interface ghmt_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] member_id;
  logic [15:0] member_port;
  logic [30:0] member_heartbeat;

  modport source (
    output valid, func, member_id, member_port, member_heartbeat,
    input  ready
  );
  modport sink (
    input  valid, func, member_id, member_port, member_heartbeat,
    output ready
  );
endinterface

interface ghmt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] entry_id;
  logic [15:0] entry_port;
  logic [30:0] entry_heartbeat;
  logic        last;

  modport source (
    output valid, event_kind, entry_id, entry_port, entry_heartbeat, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, entry_id, entry_port, entry_heartbeat, last,
    output ready
  );
endinterface

>>> hdl/ghmt_mem.sv
module ghmt_mem #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  ghmt_pkg::entry_t         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output ghmt_pkg::entry_t         rdata
);
  import ghmt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/ghmt_out.sv
module ghmt_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ghmt_pkg::result_t res,
  output logic              can_push,
  ghmt_out_if.source        out_if
);
  import ghmt_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign can_push = !vld_r || out_if.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (push) begin
      vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_if.valid           = vld_r;
  assign out_if.event_kind      = res_r.kind;
  assign out_if.entry_id        = res_r.id;
  assign out_if.entry_port      = res_r.port;
  assign out_if.entry_heartbeat = res_r.beat;
  assign out_if.last            = res_r.last;

endmodule

>>> hdl/gossip_heartbeat_membership_table.sv
// Gossip heartbeat membership table. Entries (id, port, heartbeat, stamp) live in a
// TABLE_DEPTH-deep entry memory with one read port; slot zero is this node, with id
// and port taken from the own_id and own_port registers. A merge transaction walks the
// slots one per cycle through the memory read port; its one result is then pushed into
// the output register (with no walk when it matches self). A tick transaction walks the
// slots twice, once to remove aged entries and once to emit the gossip list, then emits
// the self entry as its final result. A tick walk pauses, and a merge holds its result,
// while the result channel holds a result back. At most 32 results per tick; self is
// always the last. One transaction is in work at a time; the output register lets the
// next one be taken while the final result still waits.
`include "gossip_heartbeat_membership_table_defines.svh"

module gossip_heartbeat_membership_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ghmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ghmt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ghmt_in_if.sink                         in_if,
  ghmt_out_if.source                      out_if
);
  import ghmt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MSRCH = 6'b000010,
    S_MDONE = 6'b000100,
    S_TREM  = 6'b001000,
    S_TGOS  = 6'b010000,
    S_TSELF = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] own_id_r;
  logic [15:0] own_port_r;
  logic [15:0] fail_to_r;
  logic [15:0] rem_to_r;

  logic [31:0]            cur_time_r, cur_time_nxt;
  logic [30:0]            own_hb_r, own_hb_nxt;
  logic [30:0]            self_beat_r, self_beat_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       found_idx_r, found_idx_nxt;
  logic [30:0]            found_beat_r, found_beat_nxt;
  logic                   free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;
  logic [EMIT_W-1:0]      emit_cnt_r, emit_cnt_nxt;

  logic [31:0] item_id_r, item_id_nxt;
  logic [15:0] item_port_r, item_port_nxt;
  logic [30:0] item_beat_r, item_beat_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  logic    push;
  logic    out_ok;
  result_t res;

  logic        in_acc;
  logic        hit;
  logic        rm_hit;
  logic        gs_hit;
  logic        chk_last;
  logic        issue_ok;
  logic        room;
  logic        need;
  logic        stall;
  logic [31:0] age;

  ghmt_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_q)
  );

  ghmt_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res      (res),
    .can_push (out_ok),
    .out_if   (out_if)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && (state_r == S_IDLE);

  assign age      = cur_time_r - rd_q.stamp;
  assign hit      = chk_vld_r && valid_r[chk_idx_r] &&
                    (rd_q.id == item_id_r) && (rd_q.port == item_port_r);
  assign rm_hit   = chk_vld_r && valid_r[chk_idx_r] && (age >= {16'd0, rem_to_r});
  assign gs_hit   = chk_vld_r && valid_r[chk_idx_r] && (age < {16'd0, fail_to_r});
  assign chk_last = (chk_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign issue_ok = (rd_idx_r < CNT_W'(TABLE_DEPTH));
  assign room     = (emit_cnt_r != EMIT_CAP);

  always_comb begin
    state_nxt      = state_r;
    cur_time_nxt   = cur_time_r;
    own_hb_nxt     = own_hb_r;
    self_beat_nxt  = self_beat_r;
    valid_nxt      = valid_r;
    rd_idx_nxt     = rd_idx_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    found_beat_nxt = found_beat_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    emit_cnt_nxt   = emit_cnt_r;
    item_id_nxt    = item_id_r;
    item_port_nxt  = item_port_r;
    item_beat_nxt  = item_beat_r;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[IDX_W-1:0];
    mem_we         = 1'b0;
    mem_waddr      = found_idx_r;
    mem_wdata      = '{id: item_id_r, port: item_port_r, beat: item_beat_r,
                       stamp: cur_time_r};
    push           = 1'b0;
    res            = '{kind: EV_GOSSIP, id: own_id_r, port: own_port_r,
                       beat: self_beat_r, last: 1'b1};
    need           = 1'b0;
    stall          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_id_nxt   = in_if.member_id;
          item_port_nxt = in_if.member_port;
          item_beat_nxt = in_if.member_heartbeat;
          rd_idx_nxt    = CNT_W'(1);
          chk_vld_nxt   = 1'b0;
          if (in_if.func) begin
            cur_time_nxt  = cur_time_r + 32'd1;
            own_hb_nxt    = (own_hb_r == BEAT_MAX) ? own_hb_r : own_hb_r + 31'd1;
            self_beat_nxt = own_hb_nxt;
            emit_cnt_nxt  = '0;
            state_nxt     = S_TREM;
          end else begin
            found_nxt      = (in_if.member_id == own_id_r) &&
                             (in_if.member_port == own_port_r);
            found_idx_nxt  = '0;
            found_beat_nxt = self_beat_r;
            free_vld_nxt   = 1'b0;
            state_nxt      = found_nxt ? S_MDONE : S_MSRCH;
          end
        end
      end

      S_MSRCH: begin
        rd_en       = issue_ok;
        chk_vld_nxt = issue_ok;
        chk_idx_nxt = rd_idx_r[IDX_W-1:0];
        if (issue_ok) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (hit) begin
          found_nxt      = 1'b1;
          found_idx_nxt  = chk_idx_r;
          found_beat_nxt = rd_q.beat;
          chk_vld_nxt    = 1'b0;
          state_nxt      = S_MDONE;
        end else begin
          if (chk_vld_r && !valid_r[chk_idx_r] && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (chk_vld_r && chk_last) begin
            chk_vld_nxt = 1'b0;
            state_nxt   = S_MDONE;
          end
        end
      end

      S_MDONE: begin
        res = '{kind: EV_DROPPED, id: item_id_r, port: item_port_r,
                beat: item_beat_r, last: 1'b1};
        if (found_r) begin
          if (item_beat_r > found_beat_r) begin
            res.kind = EV_UPDATED;
          end else begin
            res.kind = EV_STALE;
            res.beat = found_beat_r;
          end
        end else if (free_vld_r) begin
          res.kind = EV_ADDED;
        end
        if (out_ok) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
          if (found_r && (item_beat_r > found_beat_r)) begin
            if (found_idx_r == '0) begin
              self_beat_nxt = item_beat_r;
            end else begin
              mem_we = 1'b1;
            end
          end else if (!found_r && free_vld_r) begin
            mem_we                = 1'b1;
            mem_waddr             = free_idx_r;
            valid_nxt[free_idx_r] = 1'b1;
          end
        end
      end

      S_TREM, S_TGOS: begin
        need  = ((state_r == S_TREM) ? rm_hit : gs_hit) && room;
        stall = need && !out_ok;
        res   = '{kind: (state_r == S_TREM) ? EV_REMOVED : EV_GOSSIP, id: rd_q.id,
                  port: rd_q.port, beat: rd_q.beat, last: 1'b0};
        if (!stall) begin
          rd_en       = issue_ok;
          chk_vld_nxt = issue_ok;
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
          if (issue_ok) begin
            rd_idx_nxt = rd_idx_r + CNT_W'(1);
          end
          if ((state_r == S_TREM) && rm_hit) begin
            valid_nxt[chk_idx_r] = 1'b0;
          end
          if (need) begin
            push         = 1'b1;
            emit_cnt_nxt = emit_cnt_r + EMIT_W'(1);
          end
          if (chk_vld_r && chk_last) begin
            rd_idx_nxt  = CNT_W'(1);
            chk_vld_nxt = 1'b0;
            state_nxt   = (state_r == S_TREM) ? S_TGOS : S_TSELF;
          end
        end
      end

      S_TSELF: begin
        if (out_ok) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      own_id_r     <= '0;
      own_port_r   <= '0;
      fail_to_r    <= FAIL_TO_RST;
      rem_to_r     <= REMOVE_TO_RST;
      cur_time_r   <= '0;
      own_hb_r     <= '0;
      self_beat_r  <= '0;
      valid_r      <= TABLE_DEPTH'(1);
      rd_idx_r     <= '0;
      chk_vld_r    <= 1'b0;
      chk_idx_r    <= '0;
      found_r      <= 1'b0;
      found_idx_r  <= '0;
      free_vld_r   <= 1'b0;
      free_idx_r   <= '0;
      emit_cnt_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      cur_time_r   <= cur_time_nxt;
      own_hb_r     <= own_hb_nxt;
      self_beat_r  <= self_beat_nxt;
      valid_r      <= valid_nxt;
      rd_idx_r     <= rd_idx_nxt;
      chk_vld_r    <= chk_vld_nxt;
      chk_idx_r    <= chk_idx_nxt;
      found_r      <= found_nxt;
      found_idx_r  <= found_idx_nxt;
      free_vld_r   <= free_vld_nxt;
      free_idx_r   <= free_idx_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ID:    own_id_r   <= cfg_wdata;
          CFG_OWN_PORT:  own_port_r <= cfg_wdata[15:0];
          CFG_FAIL_TO:   fail_to_r  <= cfg_wdata[15:0];
          CFG_REMOVE_TO: rem_to_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    found_beat_r <= found_beat_nxt;
    item_id_r    <= item_id_nxt;
    item_port_r  <= item_port_nxt;
    item_beat_r  <= item_beat_nxt;
  end

  `GHMT_ASSERT_IMPL(a_push_room, push, out_ok)
  `GHMT_ASSERT_NEXT(a_last_idle, push && res.last, state_r == S_IDLE)
  `GHMT_ASSERT_IMPL(a_chk_walk, chk_vld_r, |(state_r & (S_MSRCH | S_TREM | S_TGOS)))
  `GHMT_ASSERT_IMPL(a_we_done, mem_we, (state_r == S_MDONE) && push)
  `GHMT_ASSERT_NEXT(a_tick_time, in_acc && in_if.func, cur_time_r == $past(cur_time_r) + 32'd1)

endmodule
